// ===== src/fstk_pkg.sv =====
// Shared types and constants for the Forth stack execute unit.
// Used by fstk_front, fstk_queue, fstk_back and the top level.
package fstk_pkg;

    typedef enum logic [4:0] {
        OP_PUSH  = 5'd0,  OP_ADD   = 5'd1,  OP_SUB   = 5'd2,  OP_MUL   = 5'd3,
        OP_DIV   = 5'd4,  OP_REM   = 5'd5,  OP_EQ    = 5'd6,  OP_NE    = 5'd7,
        OP_GE    = 5'd8,  OP_LE    = 5'd9,  OP_GT    = 5'd10, OP_LT    = 5'd11,
        OP_PEEK  = 5'd12, OP_POP   = 5'd13, OP_EMIT  = 5'd14, OP_SIZE  = 5'd15,
        OP_CR    = 5'd16, OP_DUP   = 5'd17, OP_DROP  = 5'd18, OP_SWAP  = 5'd19,
        OP_OVER  = 5'd20, OP_ROT   = 5'd21, OP_STORE = 5'd22, OP_LOAD  = 5'd23
    } opcode_t;

    localparam logic [1:0] KIND_NONE = 2'd0;
    localparam logic [1:0] KIND_DEC  = 2'd1;
    localparam logic [1:0] KIND_CHAR = 2'd2;
    localparam logic [1:0] KIND_NL   = 2'd3;

    localparam logic [2:0] ERR_OK    = 3'd0;
    localparam logic [2:0] ERR_UNDER = 3'd1;
    localparam logic [2:0] ERR_OVER  = 3'd2;
    localparam logic [2:0] ERR_DIVZ  = 3'd3;
    localparam logic [2:0] ERR_INDEX = 3'd4;

    // Decoded word as it travels from front to back
    typedef struct packed {
        opcode_t     op;
        logic        known;     // opcode 0..23
        logic [31:0] imm;
        logic [6:0]  idx;
        logic [1:0]  need;      // entries required on the stack
        logic        grow;      // word adds one entry
        logic        shrink;    // word removes one entry
        logic        idx_bad;   // memory word with index out of range
        logic        is_div;    // div or rem
    } instr_t;

    typedef enum logic [2:0] {
        ST_CLEAR, ST_IDLE, ST_SETTLE, ST_DIV, ST_DIVFIN, ST_LOAD
    } back_state_t;

endpackage

// ===== src/forth_stack_execute_unit_top.sv =====
// Forth stack execute unit: one word per transaction, one result per word.
// Most words pass from IDLE through SETTLE; load waits in LOAD for the word
// memory read, and div and rem run a 32-step iterative divider. The back end
// takes a new word only once the last is done, SETTLE letting the spill memory
// read follow each stack change. Reset: stack empties at once; word memory is
// cleared one entry at a time, during which s_ready stays low.
module forth_stack_execute_unit_top #(
    parameter int STACK_DEPTH = 64,
    parameter int MEM_DEPTH   = 128
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [4:0]  s_opcode,
    input  logic [31:0] s_immediate,
    input  logic [6:0]  s_mem_index,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_print_kind,
    output logic [31:0] m_print_value,
    output logic [2:0]  m_error_code
);

    fstk_pkg::instr_t dec_instr, head_instr;
    logic             q_full, q_valid, q_pop, clearing, s_acc;

    assign s_ready = !q_full && !clearing;
    assign s_acc   = s_valid && s_ready;

    // Front: classify incoming words
    fstk_front #(.MEM_DEPTH(MEM_DEPTH)) u_front (
        .opcode    (s_opcode),
        .immediate (s_immediate),
        .mem_index (s_mem_index),
        .instr     (dec_instr)
    );

    // Queue between front and back
    fstk_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_en    (s_acc),
        .wr_data  (dec_instr),
        .full     (q_full),
        .rd_en    (q_pop),
        .rd_valid (q_valid),
        .rd_data  (head_instr)
    );

    // Back: execute on stack and memory
    fstk_back #(.STACK_DEPTH(STACK_DEPTH), .MEM_DEPTH(MEM_DEPTH)) u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .q_valid       (q_valid),
        .q_data        (head_instr),
        .q_pop         (q_pop),
        .clearing      (clearing),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_print_kind  (m_print_kind),
        .m_print_value (m_print_value),
        .m_error_code  (m_error_code)
    );

endmodule

// ===== src/fstk_front.sv =====
// Front end: takes an input transaction and classifies the word.
// Depends on fstk_pkg.
module fstk_front #(
    parameter int MEM_DEPTH = 128
) (
    input  logic [4:0]          opcode,
    input  logic [31:0]         immediate,
    input  logic [6:0]          mem_index,
    output fstk_pkg::instr_t    instr
);

    logic [4:0] op_raw;
    logic       mem_op;

    assign op_raw = opcode;
    assign mem_op = (op_raw == fstk_pkg::OP_STORE) || (op_raw == fstk_pkg::OP_LOAD);

    // Classify stack demand and growth
    always_comb begin
        instr         = '0;
        instr.op      = fstk_pkg::opcode_t'(op_raw);
        instr.known   = (op_raw <= fstk_pkg::OP_LOAD);
        instr.imm     = immediate;
        instr.idx     = mem_index;
        instr.idx_bad = mem_op && ({25'd0, mem_index} >= 32'(MEM_DEPTH));
        instr.is_div  = (op_raw == fstk_pkg::OP_DIV) || (op_raw == fstk_pkg::OP_REM);
        if (op_raw >= fstk_pkg::OP_ADD && op_raw <= fstk_pkg::OP_LT) begin
            instr.need   = 2'd2;
            instr.shrink = 1'b1;
        end
        if (op_raw == fstk_pkg::OP_PEEK || op_raw == fstk_pkg::OP_DUP) begin
            instr.need = 2'd1;
        end
        if (op_raw == fstk_pkg::OP_POP || op_raw == fstk_pkg::OP_EMIT ||
            op_raw == fstk_pkg::OP_DROP || op_raw == fstk_pkg::OP_STORE) begin
            instr.need   = 2'd1;
            instr.shrink = 1'b1;
        end
        if (op_raw == fstk_pkg::OP_SWAP || op_raw == fstk_pkg::OP_OVER) begin
            instr.need = 2'd2;
        end
        if (op_raw == fstk_pkg::OP_ROT) begin
            instr.need = 2'd3;
        end
        instr.grow = (op_raw == fstk_pkg::OP_PUSH) || (op_raw == fstk_pkg::OP_DUP) ||
                     (op_raw == fstk_pkg::OP_OVER) || (op_raw == fstk_pkg::OP_LOAD);
    end

endmodule

// ===== src/fstk_queue.sv =====
// Two-entry queue of decoded words between front and back.
// Depends on fstk_pkg.
module fstk_queue (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                wr_en,
    input  fstk_pkg::instr_t    wr_data,
    output logic                full,
    input  logic                rd_en,
    output logic                rd_valid,
    output fstk_pkg::instr_t    rd_data
);

    fstk_pkg::instr_t mem_reg [2];
    logic             wr_ptr_reg, wr_ptr_next;
    logic             rd_ptr_reg, rd_ptr_next;
    logic [1:0]       count_reg,  count_next;

    assign full     = (count_reg == 2'd2);
    assign rd_valid = (count_reg != 2'd0);
    assign rd_data  = mem_reg[rd_ptr_reg];

    // Pointer and count update
    always_comb begin
        wr_ptr_next = wr_ptr_reg ^ wr_en;
        rd_ptr_next = rd_ptr_reg ^ rd_en;
        count_next  = count_reg + {1'b0, wr_en} - {1'b0, rd_en};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Storage
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

// ===== src/fstk_back.sv =====
// Back end: executes decoded words on the data stack and word memory.
// Top three stack entries sit in registers, deeper ones in a spill memory.
// Depends on fstk_pkg.
module fstk_back #(
    parameter int STACK_DEPTH = 64,
    parameter int MEM_DEPTH   = 128
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                q_valid,
    input  fstk_pkg::instr_t    q_data,
    output logic                q_pop,
    output logic                clearing,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [1:0]          m_print_kind,
    output logic [31:0]         m_print_value,
    output logic [2:0]          m_error_code
);

    localparam int SA = $clog2(STACK_DEPTH);
    localparam int DW = $clog2(STACK_DEPTH + 1);
    localparam int WA = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;

    fstk_pkg::back_state_t state_reg, state_next;

    logic [DW-1:0] depth_reg, depth_next;
    logic [31:0]   t0_reg, t0_next, t1_reg, t1_next, t2_reg, t2_next;

    // Spill memory for entries below the top three
    logic [31:0]   spill_mem [STACK_DEPTH];
    logic [31:0]   spill_rd_reg;
    logic [SA-1:0] spill_rd_addr, spill_wr_addr;
    logic          spill_we;

    // Word memory
    logic [31:0]   wmem [MEM_DEPTH];
    logic [31:0]   wm_rd_reg;
    logic [WA-1:0] wm_addr, wm_wr_addr;
    logic [31:0]   wm_wr_data;
    logic          wm_we;
    logic [WA-1:0] clr_cnt_reg, clr_cnt_next;

    // Divider
    logic [32:0]   dv_rem_reg, dv_rem_next;
    logic [31:0]   dv_quo_reg, dv_quo_next;
    logic [31:0]   dv_den_reg, dv_den_next;
    logic [4:0]    dv_cnt_reg, dv_cnt_next;
    logic          dv_rem_op_reg, dv_rem_op_next;
    logic          dv_qneg_reg, dv_qneg_next;
    logic          dv_rneg_reg, dv_rneg_next;
    logic [32:0]   dv_shift, dv_trial;

    // Output register
    logic          m_valid_reg, m_valid_next;
    logic [1:0]    kind_reg, kind_next;
    logic [31:0]   value_reg, value_next;
    logic [2:0]    err_reg, err_next;

    logic          out_free, go;
    logic [2:0]    err_c;
    logic [31:0]   a, b, alu_r, push_val;
    logic          do_push, do_pop;

    assign out_free      = !m_valid_reg || m_ready;
    assign go            = (state_reg == fstk_pkg::ST_IDLE) && q_valid && out_free;
    assign clearing      = (state_reg == fstk_pkg::ST_CLEAR);
    assign m_valid       = m_valid_reg;
    assign m_print_kind  = kind_reg;
    assign m_print_value = value_reg;
    assign m_error_code  = err_reg;
    assign a             = t1_reg;
    assign b             = t0_reg;
    assign spill_rd_addr = SA'(depth_reg - DW'(4));
    assign spill_wr_addr = SA'(depth_reg - DW'(3));
    assign wm_addr       = WA'({25'd0, q_data.idx});

    // Error check on the word at the queue head
    always_comb begin
        priority if (q_data.idx_bad) begin
            err_c = fstk_pkg::ERR_INDEX;
        end else if (depth_reg < DW'(q_data.need)) begin
            err_c = fstk_pkg::ERR_UNDER;
        end else if (q_data.grow && (32'(depth_reg) >= 32'(STACK_DEPTH))) begin
            err_c = fstk_pkg::ERR_OVER;
        end else if (q_data.is_div && (t0_reg == 32'd0)) begin
            err_c = fstk_pkg::ERR_DIVZ;
        end else begin
            err_c = fstk_pkg::ERR_OK;
        end
    end

    // Combinational arithmetic and compares
    always_comb begin
        unique case (q_data.op)
            fstk_pkg::OP_ADD: alu_r = a + b;
            fstk_pkg::OP_SUB: alu_r = a - b;
            fstk_pkg::OP_MUL: alu_r = a * b;
            fstk_pkg::OP_EQ:  alu_r = {31'd0, a == b};
            fstk_pkg::OP_NE:  alu_r = {31'd0, a != b};
            fstk_pkg::OP_GE:  alu_r = {31'd0, $signed(a) >= $signed(b)};
            fstk_pkg::OP_LE:  alu_r = {31'd0, $signed(a) <= $signed(b)};
            fstk_pkg::OP_GT:  alu_r = {31'd0, $signed(a) > $signed(b)};
            fstk_pkg::OP_LT:  alu_r = {31'd0, $signed(a) < $signed(b)};
            default:          alu_r = t1_reg;
        endcase
    end

    // Divider step: restoring, one quotient bit per cycle
    assign dv_shift = {dv_rem_reg[31:0], dv_quo_reg[31]};
    assign dv_trial = dv_shift - {1'b0, dv_den_reg};

    // Next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            fstk_pkg::ST_CLEAR: begin
                if (32'(clr_cnt_reg) == 32'(MEM_DEPTH - 1)) begin
                    state_next = fstk_pkg::ST_IDLE;
                end
            end
            fstk_pkg::ST_IDLE: begin
                if (go) begin
                    if (err_c == fstk_pkg::ERR_OK && q_data.is_div) begin
                        state_next = fstk_pkg::ST_DIV;
                    end else if (err_c == fstk_pkg::ERR_OK &&
                                 q_data.op == fstk_pkg::OP_LOAD) begin
                        state_next = fstk_pkg::ST_LOAD;
                    end else begin
                        state_next = fstk_pkg::ST_SETTLE;
                    end
                end
            end
            fstk_pkg::ST_SETTLE: state_next = fstk_pkg::ST_IDLE;
            fstk_pkg::ST_DIV: begin
                if (dv_cnt_reg == 5'd31) begin
                    state_next = fstk_pkg::ST_DIVFIN;
                end
            end
            fstk_pkg::ST_DIVFIN: begin
                if (out_free) begin
                    state_next = fstk_pkg::ST_SETTLE;
                end
            end
            fstk_pkg::ST_LOAD: begin
                if (out_free) begin
                    state_next = fstk_pkg::ST_SETTLE;
                end
            end
            default: state_next = fstk_pkg::ST_IDLE;
        endcase
    end

    // Datapath and outputs
    always_comb begin
        depth_next     = depth_reg;
        t0_next        = t0_reg;
        t1_next        = t1_reg;
        t2_next        = t2_reg;
        clr_cnt_next   = clr_cnt_reg;
        dv_rem_next    = dv_rem_reg;
        dv_quo_next    = dv_quo_reg;
        dv_den_next    = dv_den_reg;
        dv_cnt_next    = dv_cnt_reg;
        dv_rem_op_next = dv_rem_op_reg;
        dv_qneg_next   = dv_qneg_reg;
        dv_rneg_next   = dv_rneg_reg;
        m_valid_next   = m_valid_reg && !m_ready;
        kind_next      = kind_reg;
        value_next     = value_reg;
        err_next       = err_reg;
        q_pop          = 1'b0;
        wm_we          = 1'b0;
        wm_wr_addr     = wm_addr;
        wm_wr_data     = t0_reg;
        do_push        = 1'b0;
        do_pop         = 1'b0;
        push_val       = q_data.imm;

        unique case (state_reg)
            fstk_pkg::ST_CLEAR: begin
                wm_we        = 1'b1;
                wm_wr_addr   = clr_cnt_reg;
                wm_wr_data   = 32'd0;
                clr_cnt_next = clr_cnt_reg + WA'(1);
            end
            fstk_pkg::ST_IDLE: begin
                if (go) begin
                    q_pop        = 1'b1;
                    m_valid_next = 1'b1;
                    kind_next    = fstk_pkg::KIND_NONE;
                    value_next   = 32'd0;
                    err_next     = err_c;
                    if (err_c == fstk_pkg::ERR_OK && q_data.known) begin
                        if (q_data.is_div) begin
                            m_valid_next   = 1'b0;
                            dv_rem_next    = 33'd0;
                            dv_quo_next    = a[31] ? (32'd0 - a) : a;
                            dv_den_next    = b[31] ? (32'd0 - b) : b;
                            dv_cnt_next    = 5'd0;
                            dv_rem_op_next = (q_data.op == fstk_pkg::OP_REM);
                            dv_qneg_next   = a[31] ^ b[31];
                            dv_rneg_next   = a[31];
                        end else begin
                            unique case (q_data.op)
                                fstk_pkg::OP_PUSH: do_push = 1'b1;
                                fstk_pkg::OP_PEEK: begin
                                    kind_next  = fstk_pkg::KIND_DEC;
                                    value_next = t0_reg;
                                end
                                fstk_pkg::OP_POP: begin
                                    kind_next  = fstk_pkg::KIND_DEC;
                                    value_next = t0_reg;
                                end
                                fstk_pkg::OP_EMIT: begin
                                    kind_next  = fstk_pkg::KIND_CHAR;
                                    value_next = t0_reg;
                                end
                                fstk_pkg::OP_SIZE: begin
                                    kind_next  = fstk_pkg::KIND_DEC;
                                    value_next = 32'(depth_reg);
                                end
                                fstk_pkg::OP_CR:   kind_next = fstk_pkg::KIND_NL;
                                fstk_pkg::OP_DUP: begin
                                    do_push  = 1'b1;
                                    push_val = t0_reg;
                                end
                                fstk_pkg::OP_OVER: begin
                                    do_push  = 1'b1;
                                    push_val = t1_reg;
                                end
                                fstk_pkg::OP_SWAP: begin
                                    t0_next = t1_reg;
                                    t1_next = t0_reg;
                                end
                                fstk_pkg::OP_ROT: begin
                                    t0_next = t2_reg;
                                    t1_next = t0_reg;
                                    t2_next = t1_reg;
                                end
                                fstk_pkg::OP_STORE: wm_we = 1'b1;
                                // result goes out once the memory read is back
                                fstk_pkg::OP_LOAD: m_valid_next = 1'b0;
                                default: ;
                            endcase
                            if (q_data.shrink) begin
                                do_pop = 1'b1;
                            end
                        end
                    end
                end
            end
            fstk_pkg::ST_SETTLE: ;
            fstk_pkg::ST_DIV: begin
                dv_cnt_next = dv_cnt_reg + 5'd1;
                if (!dv_trial[32]) begin
                    dv_rem_next = dv_trial;
                    dv_quo_next = {dv_quo_reg[30:0], 1'b1};
                end else begin
                    dv_rem_next = dv_shift;
                    dv_quo_next = {dv_quo_reg[30:0], 1'b0};
                end
            end
            fstk_pkg::ST_DIVFIN: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    do_pop       = 1'b1;
                end
            end
            fstk_pkg::ST_LOAD: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    do_push      = 1'b1;
                    push_val     = wm_rd_reg;
                end
            end
            default: ;
        endcase

        // Binary words and pops: new top from the ALU, the divider or the second entry
        if (do_pop) begin
            depth_next = depth_reg - DW'(1);
            t1_next    = t2_reg;
            t2_next    = spill_rd_reg;
            if (state_reg == fstk_pkg::ST_DIVFIN) begin
                if (dv_rem_op_reg) begin
                    t0_next = dv_rneg_reg ? (32'd0 - dv_rem_reg[31:0]) : dv_rem_reg[31:0];
                end else begin
                    t0_next = dv_qneg_reg ? (32'd0 - dv_quo_reg) : dv_quo_reg;
                end
            end else begin
                t0_next = alu_r;
            end
        end
        if (do_push) begin
            depth_next = depth_reg + DW'(1);
            t0_next    = push_val;
            t1_next    = t0_reg;
            t2_next    = t1_reg;
        end
    end

    assign spill_we = do_push && (depth_reg >= DW'(3));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= fstk_pkg::ST_CLEAR;
            depth_reg   <= '0;
            clr_cnt_reg <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            depth_reg   <= depth_next;
            clr_cnt_reg <= clr_cnt_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        t0_reg        <= t0_next;
        t1_reg        <= t1_next;
        t2_reg        <= t2_next;
        dv_rem_reg    <= dv_rem_next;
        dv_quo_reg    <= dv_quo_next;
        dv_den_reg    <= dv_den_next;
        dv_cnt_reg    <= dv_cnt_next;
        dv_rem_op_reg <= dv_rem_op_next;
        dv_qneg_reg   <= dv_qneg_next;
        dv_rneg_reg   <= dv_rneg_next;
        kind_reg      <= kind_next;
        value_reg     <= value_next;
        err_reg       <= err_next;
    end

    // Spill memory: one write, one registered read
    always_ff @(posedge aclk) begin
        if (spill_we) begin
            spill_mem[spill_wr_addr] <= t2_reg;
        end
        spill_rd_reg <= spill_mem[spill_rd_addr];
    end

    // Word memory: one write, one registered read captured at issue
    always_ff @(posedge aclk) begin
        if (wm_we) begin
            wmem[wm_wr_addr] <= wm_wr_data;
        end
        if (go) begin
            wm_rd_reg <= wmem[wm_addr];
        end
    end

endmodule
